@@ src/multilinear_neuron_eval_top_assert.svh @@
// Assertion macros for the neuron evaluator
`ifndef MULTILINEAR_NEURON_EVAL_TOP_ASSERT_SVH
`define MULTILINEAR_NEURON_EVAL_TOP_ASSERT_SVH
`ifndef SYNTH
`define MNEV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MNEV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MNEV_ASSERT(lbl, prop, msg)
`define MNEV_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ src/mnev_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mnev_pkg;
  localparam int MAX_INPUTS  = 4;
  localparam int STORE_DEPTH = 16;
  localparam int NUM_SEL     = 4;
  localparam int COEF_AW     = MAX_INPUTS;
  localparam int COEF_DEPTH  = 1 << MAX_INPUTS;
  localparam int ST_AW       = $clog2(STORE_DEPTH);
  localparam int IN_IDX_W    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int VAL_W       = 16;
  localparam int ACT_W       = 2;
  localparam int SLOT_W      = 4;
  localparam int N_W         = 3;
  localparam int SEL_W       = 4;
  localparam int SRC_W       = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 4;
  localparam int Q_SHIFT     = 14;
  localparam int MUL_W       = 2 * VAL_W;
  localparam int ACC_W       = VAL_W + MAX_INPUTS + 1;

  localparam logic signed [VAL_W-1:0] VAL_ONE     = 16'sd16384;
  localparam logic signed [VAL_W-1:0] VAL_NEG_ONE = -16'sd16384;
  localparam logic signed [ACC_W-1:0] ACC_ONE     = ACC_W'(16384);
  localparam logic signed [ACC_W-1:0] ACC_NEG_ONE = ACC_W'(-16384);
  localparam logic [N_W-1:0]          ACTIVE_RESET = 3'd4;

  typedef enum logic [ACT_W-1:0] {
    ACT_COEF  = 2'd0,
    ACT_STORE = 2'd1,
    ACT_EVAL  = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE     = 3'd0,
    CFG_SEL_FIRST  = 3'd1,
    CFG_SEL_SECOND = 3'd2,
    CFG_SEL_THIRD  = 3'd3,
    CFG_SEL_FOURTH = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_RD,
    S_MUL1,
    S_MUL2,
    S_FIN,
    S_OUT
  } state_t;
endpackage
`default_nettype wire

@@ src/mnev_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mnev_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ src/multilinear_neuron_eval_top.sv @@
// Write requests (coefficient, store entry) are taken only in the idle state.
// An evaluate request with n active inputs loads the n inputs, then runs each of 2^n terms
// through read and two multiply states; no new request is taken until its result is output.
// One shared 16x16 multiplier serves both products of each term.
// Reset (synchronous, rst_n low) restores the register defaults and makes every
// coefficient and store entry read as zero through per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none
`include "multilinear_neuron_eval_top_assert.svh"
module multilinear_neuron_eval_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [mnev_pkg::ACT_W-1:0]             in_action,
  input  logic [mnev_pkg::SLOT_W-1:0]            in_slot,
  input  logic signed [mnev_pkg::VAL_W-1:0]      in_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [mnev_pkg::VAL_W-1:0]      out_activation,
  input  logic                                   cfg_we,
  input  logic [mnev_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mnev_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  mnev_pkg::state_t state_r, state_nxt;

  logic [mnev_pkg::N_W-1:0]   active_r;
  logic [mnev_pkg::SEL_W-1:0] sel_r [mnev_pkg::NUM_SEL];
  logic [mnev_pkg::SRC_W-1:0] src_sel [mnev_pkg::MAX_INPUTS];

  logic [mnev_pkg::COEF_DEPTH-1:0]  coef_vld_r;
  logic [mnev_pkg::STORE_DEPTH-1:0] store_vld_r;

  logic [mnev_pkg::N_W-1:0]      n_eff, n_eff_r;
  logic [mnev_pkg::IN_IDX_W-1:0] ld_cnt_r;
  logic [mnev_pkg::COEF_AW-1:0]  m_r, base_m, last_m;
  logic [mnev_pkg::IN_IDX_W-1:0] hb_idx;
  logic                          cap_vld_r;
  logic [mnev_pkg::IN_IDX_W-1:0] cap_idx_r;
  logic                          store_ok_r, coef_ok_r, acc_pend_r;

  logic signed [mnev_pkg::VAL_W-1:0] x_r [mnev_pkg::MAX_INPUTS];
  logic signed [mnev_pkg::VAL_W-1:0] coef_r;
  logic signed [mnev_pkg::MUL_W-1:0] mul_r, mul_nxt;
  logic signed [mnev_pkg::ACC_W-1:0] acc_r, term;
  logic signed [mnev_pkg::VAL_W-1:0] out_act_r, act_sat;
  logic                              out_valid_r;

  logic signed [mnev_pkg::VAL_W-1:0] val_sat, p_q, mul_a, mul_b, p_in, x_sel;
  logic                              accept, eval_go, out_load;
  logic                              coef_we, store_we, prod_we, mul_en;
  logic [mnev_pkg::SRC_W-1:0]        load_src;
  logic                              load_in_range;
  logic [mnev_pkg::ST_AW-1:0]        store_addr, store_raddr;
  logic [mnev_pkg::COEF_AW-1:0]      coef_addr;
  logic [mnev_pkg::VAL_W-1:0]        store_rdata, coef_rdata, prod_rdata;

  genvar gj;
  generate
    for (gj = 0; gj < mnev_pkg::MAX_INPUTS; gj++) begin : g_src
      if (gj < mnev_pkg::NUM_SEL) begin : g_reg
        assign src_sel[gj] = mnev_pkg::SRC_W'(sel_r[gj]);
      end else begin : g_fixed
        assign src_sel[gj] = mnev_pkg::SRC_W'(gj);
      end
    end
  endgenerate

  assign accept  = in_valid && in_ready;
  assign eval_go = accept && (in_action == mnev_pkg::ACT_EVAL);
  assign n_eff   = (active_r > mnev_pkg::N_W'(mnev_pkg::MAX_INPUTS)) ?
                   mnev_pkg::N_W'(mnev_pkg::MAX_INPUTS) : active_r;
  assign last_m  = mnev_pkg::COEF_AW'((1 << n_eff_r) - 1);

  always_comb begin
    if (in_value > mnev_pkg::VAL_ONE) begin
      val_sat = mnev_pkg::VAL_ONE;
    end else if (in_value < mnev_pkg::VAL_NEG_ONE) begin
      val_sat = mnev_pkg::VAL_NEG_ONE;
    end else begin
      val_sat = in_value;
    end
  end

  always_comb begin
    hb_idx = '0;
    for (int i = 0; i < mnev_pkg::MAX_INPUTS; i++) begin
      if (m_r[i]) begin
        hb_idx = mnev_pkg::IN_IDX_W'(i);
      end
    end
  end

  assign base_m = m_r & ~(mnev_pkg::COEF_AW'(1) << hb_idx);
  assign p_in   = (base_m == '0) ? mnev_pkg::VAL_ONE : $signed(prod_rdata);
  assign x_sel  = (m_r == '0) ? mnev_pkg::VAL_ONE : x_r[hb_idx];
  assign p_q    = mnev_pkg::VAL_W'(mul_r >>> mnev_pkg::Q_SHIFT);
  assign term   = mnev_pkg::ACC_W'(mul_r >>> mnev_pkg::Q_SHIFT);

  assign load_src      = src_sel[ld_cnt_r];
  assign load_in_range = (32'(load_src) < mnev_pkg::STORE_DEPTH);
  assign store_raddr   = mnev_pkg::ST_AW'(load_src);
  assign store_addr    = mnev_pkg::ST_AW'(in_slot);
  assign coef_addr     = mnev_pkg::COEF_AW'(in_slot);

  always_comb begin
    if (acc_r > mnev_pkg::ACC_ONE) begin
      act_sat = mnev_pkg::VAL_ONE;
    end else if (acc_r < mnev_pkg::ACC_NEG_ONE) begin
      act_sat = mnev_pkg::VAL_NEG_ONE;
    end else begin
      act_sat = mnev_pkg::VAL_W'(acc_r);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mnev_pkg::S_IDLE: begin
        if (eval_go) begin
          state_nxt = (n_eff == '0) ? mnev_pkg::S_RD : mnev_pkg::S_LOAD;
        end
      end
      mnev_pkg::S_LOAD: begin
        if (mnev_pkg::N_W'(ld_cnt_r) == n_eff_r - mnev_pkg::N_W'(1)) begin
          state_nxt = mnev_pkg::S_RD;
        end
      end
      mnev_pkg::S_RD:   state_nxt = mnev_pkg::S_MUL1;
      mnev_pkg::S_MUL1: state_nxt = mnev_pkg::S_MUL2;
      mnev_pkg::S_MUL2: begin
        state_nxt = (m_r == last_m) ? mnev_pkg::S_FIN : mnev_pkg::S_RD;
      end
      mnev_pkg::S_FIN:  state_nxt = mnev_pkg::S_OUT;
      mnev_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = mnev_pkg::S_IDLE;
        end
      end
      default: state_nxt = mnev_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    coef_we  = 1'b0;
    store_we = 1'b0;
    prod_we  = 1'b0;
    mul_en   = 1'b0;
    mul_a    = p_in;
    mul_b    = x_sel;
    case (state_r)
      mnev_pkg::S_IDLE: begin
        in_ready = 1'b1;
        coef_we  = accept && (in_action == mnev_pkg::ACT_COEF) &&
                   (32'(in_slot) < mnev_pkg::COEF_DEPTH);
        store_we = accept && (in_action == mnev_pkg::ACT_STORE) &&
                   (32'(in_slot) < mnev_pkg::STORE_DEPTH);
      end
      mnev_pkg::S_MUL1: begin
        mul_en = 1'b1;
      end
      mnev_pkg::S_MUL2: begin
        mul_en  = 1'b1;
        prod_we = 1'b1;
        mul_a   = p_q;
        mul_b   = coef_r;
      end
      mnev_pkg::S_OUT: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
      end
    endcase
  end

  assign mul_nxt = mnev_pkg::MUL_W'(mul_a) * mnev_pkg::MUL_W'(mul_b);

  mnev_ram #(.WIDTH(mnev_pkg::VAL_W), .DEPTH(mnev_pkg::COEF_DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_addr),
    .wdata (val_sat),
    .raddr (m_r),
    .rdata (coef_rdata)
  );

  mnev_ram #(.WIDTH(mnev_pkg::VAL_W), .DEPTH(mnev_pkg::STORE_DEPTH)) u_store_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_addr),
    .wdata (val_sat),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  mnev_ram #(.WIDTH(mnev_pkg::VAL_W), .DEPTH(mnev_pkg::COEF_DEPTH)) u_prod_ram (
    .clk   (clk),
    .we    (prod_we),
    .waddr (m_r),
    .wdata (p_q),
    .raddr (base_m),
    .rdata (prod_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mnev_pkg::S_IDLE;
      active_r    <= mnev_pkg::ACTIVE_RESET;
      for (int j = 0; j < mnev_pkg::NUM_SEL; j++) begin
        sel_r[j] <= mnev_pkg::SEL_W'(j);
      end
      coef_vld_r  <= '0;
      store_vld_r <= '0;
      cap_vld_r   <= 1'b0;
      acc_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      n_eff_r     <= '0;
      ld_cnt_r    <= '0;
      m_r         <= '0;
    end else begin
      state_r    <= state_nxt;
      cap_vld_r  <= (state_r == mnev_pkg::S_LOAD);
      acc_pend_r <= (state_r == mnev_pkg::S_MUL2);
      if (cfg_we) begin
        case (cfg_index)
          mnev_pkg::CFG_ACTIVE:     active_r <= cfg_wdata[mnev_pkg::N_W-1:0];
          mnev_pkg::CFG_SEL_FIRST:  sel_r[0] <= cfg_wdata[mnev_pkg::SEL_W-1:0];
          mnev_pkg::CFG_SEL_SECOND: sel_r[1] <= cfg_wdata[mnev_pkg::SEL_W-1:0];
          mnev_pkg::CFG_SEL_THIRD:  sel_r[2] <= cfg_wdata[mnev_pkg::SEL_W-1:0];
          mnev_pkg::CFG_SEL_FOURTH: sel_r[3] <= cfg_wdata[mnev_pkg::SEL_W-1:0];
          default: begin
          end
        endcase
      end
      if (coef_we) begin
        coef_vld_r[coef_addr] <= 1'b1;
      end
      if (store_we) begin
        store_vld_r[store_addr] <= 1'b1;
      end
      if (eval_go) begin
        n_eff_r  <= n_eff;
        ld_cnt_r <= '0;
        m_r      <= '0;
      end
      if (state_r == mnev_pkg::S_LOAD) begin
        ld_cnt_r <= ld_cnt_r + mnev_pkg::IN_IDX_W'(1);
      end
      if (state_r == mnev_pkg::S_MUL2) begin
        m_r <= m_r + mnev_pkg::COEF_AW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cap_idx_r  <= ld_cnt_r;
    store_ok_r <= load_in_range && store_vld_r[store_raddr];
    coef_ok_r  <= coef_vld_r[m_r];
    if (cap_vld_r) begin
      x_r[cap_idx_r] <= store_ok_r ? $signed(store_rdata) : '0;
    end
    if (state_r == mnev_pkg::S_MUL1) begin
      coef_r <= coef_ok_r ? $signed(coef_rdata) : '0;
    end
    if (mul_en) begin
      mul_r <= mul_nxt;
    end
    if (eval_go) begin
      acc_r <= '0;
    end else if (acc_pend_r) begin
      acc_r <= acc_r + term;
    end
    if (out_load) begin
      out_act_r <= act_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_activation = out_act_r;

  `MNEV_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid && in_ready, "reset left a result or busy state")
  `MNEV_ASSERT(a_out_range, out_valid |-> (out_activation <= mnev_pkg::VAL_ONE && out_activation >= mnev_pkg::VAL_NEG_ONE), "activation outside unit range")
  `MNEV_ASSERT(a_out_from_seq, $rose(out_valid) |-> $past(state_r == mnev_pkg::S_OUT), "result raised outside output state")
  `MNEV_ASSERT(a_acc_after_mul, acc_pend_r |-> $past(state_r == mnev_pkg::S_MUL2), "accumulate without second product")
  `MNEV_ASSERT(a_load_bound, state_r == mnev_pkg::S_LOAD |-> mnev_pkg::N_W'(ld_cnt_r) < n_eff_r, "input load past active count")
endmodule
`default_nettype wire
